/* sv/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// shared types, token kinds, keyword table and result queue sizing
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam logic [2:0] KIND_NUM   = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_RES   = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    localparam int KW_COUNT   = 4;
    localparam int RESULT_MAX = 3;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start_res;
        logic [16:0] length;
        logic [63:0] value;
        logic        final_res;
    } token_t;

    typedef struct packed {
        logic [1:0]        count;
        token_t [2:0]      tok;
    } push_t;

    // keyword spelling: return, if, else, for
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        case ({k, i})
            5'b00_000: c = 8'h72;
            5'b00_001: c = 8'h65;
            5'b00_010: c = 8'h74;
            5'b00_011: c = 8'h75;
            5'b00_100: c = 8'h72;
            5'b00_101: c = 8'h6E;
            5'b01_000: c = 8'h69;
            5'b01_001: c = 8'h66;
            5'b10_000: c = 8'h65;
            5'b10_001: c = 8'h6C;
            5'b10_010: c = 8'h73;
            5'b10_011: c = 8'h65;
            5'b11_000: c = 8'h66;
            5'b11_001: c = 8'h6F;
            5'b11_010: c = 8'h72;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] n;
        case (k)
            2'd0:    n = 3'd6;
            2'd1:    n = 3'd2;
            2'd2:    n = 3'd4;
            2'd3:    n = 3'd3;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

/* sv/cst_byte_if.sv */
// ----------------------------------------------------------------------------
// cst_byte_if
// source text channel, one byte per beat
// ----------------------------------------------------------------------------
interface cst_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

/* sv/cst_token_if.sv */
// ----------------------------------------------------------------------------
// cst_token_if
// token record channel, one record per beat
// ----------------------------------------------------------------------------
interface cst_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] start_res;
    logic [16:0] length;
    logic [63:0] value;
    logic        final_res;

    modport source (output valid, output kind, output start_res, output length,
                    output value, output final_res, input ready);
    modport sink   (input valid, input kind, input start_res, input length,
                    input value, input final_res, output ready);
endinterface

/* sv/cst_lexer.sv */
// ----------------------------------------------------------------------------
// cst_lexer
// input byte register, scanner state and per-byte token generation
// ----------------------------------------------------------------------------
module cst_lexer
    import cst_pkg::*;
#(
    parameter int MAX_INPUT    = 65536,
    parameter int NUMBER_WIDTH = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  take,
    input  byte_t beat,
    output logic  busy,
    output push_t push
);

    localparam int TL_W = $clog2(MAX_INPUT + 1);
    localparam int NW   = NUMBER_WIDTH;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_NUM   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;
    localparam logic [1:0] MODE_PEND  = 2'd3;

    logic            busy_reg;
    logic [7:0]      ch_reg;
    logic            last_reg;
    logic [1:0]      mode_reg,  mode_next;
    logic [15:0]     pos_reg,   pos_next;
    logic [15:0]     begin_reg, begin_next;
    logic [TL_W-1:0] len_reg,   len_next;
    logic [NW-1:0]   acc_reg,   acc_next;
    logic [3:0]      mask_reg,  mask_next;
    logic            err_reg,   err_next;

    logic            is_sp, is_dg, is_hd, is_tl, is_pn, is_pd;
    logic            ext_num, ext_id, pair;
    logic [3:0]      digit;
    logic [NW+3:0]   num_wide;
    logic [TL_W-1:0] len_inc;
    logic [3:0]      miss, first;
    token_t          tok_a, tok_b, tok_c, tok_d;
    logic            va, vb, vc, vd;
    token_t [2:0]    ent;
    logic [2:0]      ev;
    logic [1:0]      cnt;

    function automatic token_t close_tok(input logic [1:0] m, input logic [15:0] b,
                                         input logic [TL_W-1:0] l, input logic [NW-1:0] a,
                                         input logic [3:0] msk);
        token_t          t;
        logic [TL_W+16:0] lx;
        logic [NW+63:0]   vx;
        t         = '0;
        lx        = {17'b0, l};
        vx        = {64'b0, a};
        t.start_res = b;
        t.length  = lx[16:0];
        case (m)
            MODE_NUM:
            begin
                t.kind  = KIND_NUM;
                t.value = vx[63:0];
            end
            MODE_IDENT:
            begin
                t.kind = KIND_IDENT;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (msk[k] && l == TL_W'(kw_len(2'(k))))
                    begin
                        t.kind = KIND_RES;
                    end
                end
            end
            MODE_PEND:
            begin
                t.kind   = KIND_RES;
                t.length = 17'd1;
            end
            default:
            begin
                t.kind = KIND_RES;
            end
        endcase
        return t;
    endfunction

    always_comb
    begin
        is_sp = (ch_reg == CH_SPACE) || (ch_reg >= 8'h09 && ch_reg <= 8'h0D);
        is_dg = (ch_reg >= 8'h30 && ch_reg <= 8'h39);
        is_hd = (ch_reg >= 8'h61 && ch_reg <= 8'h7A) || (ch_reg >= 8'h41 && ch_reg <= 8'h5A)
                || (ch_reg == CH_UNDER);
        is_tl = is_hd || is_dg;
        is_pn = (ch_reg >= 8'h21 && ch_reg <= 8'h7E) && !is_tl;
        is_pd = (ch_reg == CH_EQ) || (ch_reg == CH_BANG) || (ch_reg == CH_LT)
                || (ch_reg == CH_GT);
        digit = ch_reg[3:0];
        ext_num = (mode_reg == MODE_NUM) && is_dg;
        ext_id  = (mode_reg == MODE_IDENT) && is_tl;
        pair    = (mode_reg == MODE_PEND) && (ch_reg == CH_EQ);
        num_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (NW+4)'(digit);
        len_inc  = (len_reg < TL_W'(MAX_INPUT)) ? len_reg + TL_W'(1) : len_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            miss[k]  = (len_reg >= TL_W'(kw_len(2'(k))))
                       || (kw_char(2'(k), len_reg[2:0]) != ch_reg);
            first[k] = (kw_char(2'(k), 3'd0) == ch_reg);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        va = 1'b0;
        vb = 1'b0;
        vc = 1'b0;
        vd = 1'b0;
        tok_a = close_tok(mode_reg, begin_reg, len_reg, acc_reg, mask_reg);
        tok_b = '0;
        tok_d = '0;
        if (busy_reg)
        begin
            pos_next = pos_reg + 16'd1;
            if (!err_reg)
            begin
                if (ext_num)
                begin
                    acc_next = (num_wide[NW+3:NW] != 4'd0) ? {NW{1'b1}} : num_wide[NW-1:0];
                    len_next = len_inc;
                end
                else if (ext_id)
                begin
                    mask_next = mask_reg & ~miss;
                    len_next  = len_inc;
                end
                else if (pair)
                begin
                    vb              = 1'b1;
                    tok_b.kind      = KIND_RES;
                    tok_b.start_res = begin_reg;
                    tok_b.length    = 17'd2;
                    mode_next       = MODE_IDLE;
                end
                else
                begin
                    va        = (mode_reg != MODE_IDLE);
                    mode_next = MODE_IDLE;
                    if (is_sp)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_dg)
                    begin
                        mode_next  = MODE_NUM;
                        begin_next = pos_reg;
                        len_next   = TL_W'(1);
                        acc_next   = NW'(digit);
                    end
                    else if (is_hd)
                    begin
                        mode_next  = MODE_IDENT;
                        begin_next = pos_reg;
                        len_next   = TL_W'(1);
                        mask_next  = first;
                    end
                    else if (is_pd)
                    begin
                        mode_next  = MODE_PEND;
                        begin_next = pos_reg;
                        len_next   = TL_W'(1);
                    end
                    else
                    begin
                        vb              = 1'b1;
                        tok_b.kind      = is_pn ? KIND_RES : KIND_BAD;
                        tok_b.start_res = pos_reg;
                        tok_b.length    = 17'd1;
                        err_next        = !is_pn;
                    end
                end
            end
            vc = last_reg && !err_next && (mode_next != MODE_IDLE);
            if (last_reg)
            begin
                vd              = 1'b1;
                tok_d.kind      = KIND_END;
                tok_d.start_res = pos_next;
            end
        end
        tok_c = close_tok(mode_next, begin_next, len_next, acc_next, mask_next);
        if (busy_reg && last_reg)
        begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
            len_next   = '0;
            acc_next   = '0;
            mask_next  = '1;
            err_next   = 1'b0;
        end
    end

    // pack the records of this byte in order, final flag on the last one
    always_comb
    begin
        ent[0] = tok_a;
        ent[1] = vb ? tok_b : tok_c;
        ent[2] = tok_d;
        ev     = {vd, vb || vc, va};
        cnt    = 2'd0;
        push   = '0;
        for (int i = 0; i < RESULT_MAX; i++)
        begin
            if (ev[i])
            begin
                push.tok[cnt] = ent[i];
                cnt           = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0)
        begin
            push.tok[cnt - 2'd1].final_res = 1'b1;
        end
        push.count = cnt;
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            mask_reg  <= '1;
            err_reg   <= 1'b0;
        end
        else
        begin
            busy_reg  <= take;
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            mask_reg  <= mask_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg   <= beat.ch;
            last_reg <= beat.last;
        end
    end

    // the last byte always yields at least the end record
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last_reg) |-> (push.count != 2'd0))
        else $error("last byte produced no record");

    a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (mode_reg == MODE_IDLE))
        else $error("open token while in error");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (push.count == 2'd0))
        else $error("records pushed with no byte held");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last_reg) |=> (pos_reg == 16'd0 && mode_reg == MODE_IDLE && !err_reg))
        else $error("state not cleared after last byte");

endmodule

/* sv/cst_token_fifo.sv */
// ----------------------------------------------------------------------------
// cst_token_fifo
// result queue: takes up to three records per cycle, sends one per beat
// ----------------------------------------------------------------------------
module cst_token_fifo
    import cst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    output logic [FIFO_CW-1:0] level,
    cst_token_if.source        tokens
);

    token_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg, head_next;
    logic [FIFO_AW-1:0] tail_reg, tail_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;
    token_t             head_tok;

    assign head_tok         = mem[head_reg];
    assign tokens.valid     = (count_reg != '0);
    assign tokens.kind      = head_tok.kind;
    assign tokens.start_res = head_tok.start_res;
    assign tokens.length    = head_tok.length;
    assign tokens.value     = head_tok.value;
    assign tokens.final_res = head_tok.final_res;
    assign level            = count_reg;

    always_comb
    begin
        pop        = tokens.valid && tokens.ready;
        head_next  = head_reg + FIFO_AW'(pop);
        tail_next  = tail_reg + FIFO_AW'(push.count);
        count_next = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RESULT_MAX; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem[tail_reg + FIFO_AW'(k)] <= push.tok[k];
            end
        end
    end

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(count_reg) + int'(push.count) - int'(pop)) <= FIFO_DEPTH)
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (FIFO_AW'(tail_reg - head_reg) == count_reg[FIFO_AW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

/* sv/c_subset_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// c_subset_tokenizer_core
// streaming tokenizer for a small c subset: bytes in, token records out
//
//   channel   dir   beat carries
//   text      in    ch, last
//   tokens    out   kind, start_res, length, value, final_res
//
// one byte per cycle sustained; a byte is registered, scanned in the next
// cycle and its zero to three records land in an eight-entry result queue
// records leave one per beat, so bytes yielding several records slow intake
// text.ready drops while the queue cannot take the worst case of the byte
// being scanned plus a new one
// reset clears scanner state and queue; the last byte returns to reset state
// ----------------------------------------------------------------------------
module c_subset_tokenizer_core
    import cst_pkg::*;
#(
    parameter int MAX_INPUT    = 65536,
    parameter int NUMBER_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    cst_byte_if.sink    text,
    cst_token_if.source tokens
);

    logic               take;
    logic               busy;
    byte_t              beat;
    push_t              push;
    logic [FIFO_CW-1:0] level;
    logic [FIFO_CW:0]   need;

    always_comb
    begin
        need = {1'b0, level} + (busy ? (FIFO_CW+1)'(RESULT_MAX) : '0)
               + (FIFO_CW+1)'(RESULT_MAX);
        text.ready = (need <= (FIFO_CW+1)'(FIFO_DEPTH));
        take       = text.valid && text.ready;
        beat.ch    = text.ch;
        beat.last  = text.last;
    end

    cst_lexer #(
        .MAX_INPUT    (MAX_INPUT),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (beat),
        .busy  (busy),
        .push  (push)
    );

    cst_token_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .level  (level),
        .tokens (tokens)
    );

endmodule

/* dv/c_subset_tokenizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_tokenizer_core_tb
// self-checking bench for the streaming c subset tokenizer
//
// drives source text one byte per beat and predicts the token records in the
// bench. a short table of directed bytes comes first, with the record typed in
// where it is obvious, then randomly built texts with random gaps on both
// sides and one long receiver hold. each record beat is compared in order.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_core_tb;
    import cst_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_TOKS  = 60;
    localparam int RANDOM_BYTES     = 290;
    localparam int DRAIN_CYCLES     = 16;
    localparam int DIRECTED_ROWS    = 25;
    localparam logic [63:0] NUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [16:0] LEN_MAX = 17'h10000;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_PEND} scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        token_t     tok;
    } stim_row_t;

    localparam token_t NO_TOKEN = '0;

    logic clk;
    logic rst_n;

    cst_byte_if  text_if ();
    cst_token_if tokens_if ();

    c_subset_tokenizer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .tokens (tokens_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // scanner state of the predictor
    scan_mode_t  scan_mode;
    logic [15:0] src_pos;
    logic [15:0] tok_begin;
    logic [16:0] tok_len;
    logic [63:0] num_acc;
    logic [3:0]  kw_alive;
    logic        err_seen;

    token_t     step_tokens[$];
    token_t     awaited_tokens[$];
    logic [7:0] text_buf[$];

    int  mismatch_count = 0;
    int  tokens_seen    = 0;
    int  scanned_bytes  = 0;

    function automatic string kw_spell(input int k);
        case (k)
            0:       return "return";
            1:       return "if";
            2:       return "else";
            default: return "for";
        endcase
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic reset_scanner();
        scan_mode = SCAN_IDLE;
        src_pos   = '0;
        tok_begin = '0;
        tok_len   = '0;
        num_acc   = '0;
        kw_alive  = '1;
        err_seen  = 1'b0;
    endtask

    task automatic add_token(input logic [2:0] kind, input logic [15:0] start,
                             input logic [16:0] len, input logic [63:0] val);
        token_t t;
        t.kind      = kind;
        t.start_res = start;
        t.length    = len;
        t.value     = val;
        t.final_res = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic close_token();
        logic [2:0] k;
        string      w;
        case (scan_mode)
            SCAN_NUM:
                add_token(KIND_NUM, tok_begin, tok_len, num_acc);
            SCAN_IDENT:
            begin
                k = KIND_IDENT;
                for (int i = 0; i < KW_COUNT; i++)
                begin
                    w = kw_spell(i);
                    if (kw_alive[i] && tok_len == w.len())
                        k = KIND_RES;
                end
                add_token(k, tok_begin, tok_len, 64'd0);
            end
            SCAN_PEND:
                add_token(KIND_RES, tok_begin, 17'd1, 64'd0);
            default:
            begin
            end
        endcase
        scan_mode = SCAN_IDLE;
    endtask

    // records caused by one source byte, left in step_tokens
    task automatic tokenize_byte(input logic [7:0] c, input logic is_last);
        logic [63:0] d;
        bit          used;
        string       w;
        step_tokens.delete();
        used = 1'b0;
        if (!err_seen)
        begin
            if (scan_mode == SCAN_NUM && is_digit(c))
            begin
                d = {56'd0, c} - 64'h30;
                if (num_acc > (NUM_MAX - d) / 64'd10)
                    num_acc = NUM_MAX;
                else
                    num_acc = num_acc * 64'd10 + d;
                if (tok_len < LEN_MAX)
                    tok_len++;
                used = 1'b1;
            end
            else if (scan_mode == SCAN_IDENT && (is_head(c) || is_digit(c)))
            begin
                for (int i = 0; i < KW_COUNT; i++)
                begin
                    w = kw_spell(i);
                    if (tok_len >= w.len() || w[tok_len] != c)
                        kw_alive[i] = 1'b0;
                end
                if (tok_len < LEN_MAX)
                    tok_len++;
                used = 1'b1;
            end
            else if (scan_mode == SCAN_PEND && c == CH_EQ)
            begin
                add_token(KIND_RES, tok_begin, 17'd2, 64'd0);
                scan_mode = SCAN_IDLE;
                used = 1'b1;
            end
            else
                close_token();

            if (!used && !(c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)))
            begin
                if (is_digit(c))
                begin
                    scan_mode = SCAN_NUM;
                    tok_begin = src_pos;
                    tok_len   = 17'd1;
                    num_acc   = {56'd0, c} - 64'h30;
                end
                else if (is_head(c))
                begin
                    scan_mode = SCAN_IDENT;
                    tok_begin = src_pos;
                    tok_len   = 17'd1;
                    for (int i = 0; i < KW_COUNT; i++)
                    begin
                        w = kw_spell(i);
                        kw_alive[i] = (w[0] == c);
                    end
                end
                else if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT})
                begin
                    scan_mode = SCAN_PEND;
                    tok_begin = src_pos;
                    tok_len   = 17'd1;
                end
                else if (c >= 8'h21 && c <= 8'h7E)
                    add_token(KIND_RES, src_pos, 17'd1, 64'd0);
                else
                begin
                    add_token(KIND_BAD, src_pos, 17'd1, 64'd0);
                    err_seen = 1'b1;
                end
            end
        end

        src_pos++;

        if (is_last)
        begin
            if (!err_seen)
                close_token();
            add_token(KIND_END, src_pos, 17'd0, 64'd0);
            reset_scanner();
        end

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].final_res = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic is_last, input bit no_gap,
                             input logic typed, input token_t typed_tok);
        int gap;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.ch    <= c;
        text_if.last  <= is_last;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        scanned_bytes++;
        tokenize_byte(c, is_last);
        if (typed)
            awaited_tokens.push_back(typed_tok);
        else
            foreach (step_tokens[i])
                awaited_tokens.push_back(step_tokens[i]);
    endtask

    task automatic push_word(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_ident_char(input bit allow_digit);
        int r;
        r = $urandom_range(allow_digit ? 0 : 10, 62);
        if (r < 10)
            return 8'h30 + 8'(r);
        if (r < 36)
            return 8'h61 + 8'(r - 10);
        if (r < 62)
            return 8'h41 + 8'(r - 36);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? CH_SPACE : 8'h08 + 8'(r);
    endfunction

    // one random text: mostly well formed tokens, some noise and bad bytes
    task automatic send_text();
        int         pieces;
        int         r;
        int         n;
        string      w;
        logic [7:0] c;
        bit         calm;
        text_buf.delete();
        calm   = ($urandom_range(0, 3) == 0);
        pieces = $urandom_range(1, 12);
        repeat (pieces)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
                repeat (n)
                    text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            else if (r < 24)
                push_word($urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616");
            else if (r < 44)
            begin
                w = kw_spell($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:
                        push_word(w);
                    1:
                        push_word(w.substr(0, $urandom_range(0, w.len() - 2)));
                    2:
                    begin
                        push_word(w);
                        text_buf.push_back(rand_ident_char(1'b1));
                    end
                    default:
                    begin
                        text_buf.push_back(rand_ident_char(1'b0));
                        repeat ($urandom_range(0, 7))
                            text_buf.push_back(rand_ident_char(1'b1));
                    end
                endcase
            end
            else if (r < 58)
            begin
                case ($urandom_range(0, 9))
                    0:       push_word("==");
                    1:       push_word("!=");
                    2:       push_word("<=");
                    3:       push_word(">=");
                    4:       push_word("=");
                    5:       push_word("!");
                    6:       push_word("<");
                    7:       push_word(">");
                    8:       push_word("===");
                    default: push_word("!==");
                endcase
            end
            else if (r < 72)
            begin
                do
                    c = 8'($urandom_range(8'h21, 8'h7E));
                while (is_head(c) || is_digit(c));
                text_buf.push_back(c);
            end
            else if (r < 84)
                text_buf.push_back(rand_space());
            else if (r < 95)
                text_buf.push_back(8'($urandom_range(1, 255)));
            else
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while ((c >= 8'h09 && c <= 8'h0D) || (c >= 8'h20 && c <= 8'h7E));
                text_buf.push_back(c);
            end
            if ($urandom_range(0, 1))
                text_buf.push_back(rand_space());
        end
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1, calm, 1'b0, NO_TOKEN);
    endtask

    // record side: compare each beat with the oldest prediction
    always @(posedge clk)
    begin : token_check
        token_t got;
        token_t want;
        if (rst_n && tokens_if.valid && tokens_if.ready)
        begin
            got.kind      = tokens_if.kind;
            got.start_res = tokens_if.start_res;
            got.length    = tokens_if.length;
            got.value     = tokens_if.value;
            got.final_res = tokens_if.final_res;
            tokens_seen++;
            if (awaited_tokens.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("token %0d: unexpected kind=%0d start=%0d len=%0d val=%0d fin=%0d",
                             tokens_seen, got.kind, got.start_res, got.length, got.value,
                             got.final_res);
            end
            else
            begin
                want = awaited_tokens.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("token %0d: want kind=%0d start=%0d len=%0d val=%0d fin=%0d",
                                 tokens_seen, want.kind, want.start_res, want.length,
                                 want.value, want.final_res);
                        $display("token %0d: got  kind=%0d start=%0d len=%0d val=%0d fin=%0d",
                                 tokens_seen, got.kind, got.start_res, got.length,
                                 got.value, got.final_res);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus one long hold that backs up the block
    initial
    begin : token_sink
        int run_len;
        int gap;
        bit long_hold_done;
        long_hold_done = 1'b0;
        tokens_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && tokens_seen >= HOLD_AFTER_TOKS)
            begin
                tokens_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            tokens_if.ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
            gap = gap_len();
            if (gap > 0)
            begin
                tokens_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((text_if.valid && text_if.ready) || (tokens_if.valid && tokens_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("c_subset_tokenizer_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t directed_rows [DIRECTED_ROWS];
        directed_rows = '{
            '{"+",   1'b0, 1'b1, '{KIND_RES, 16'd0, 17'd1, 64'd0, 1'b1}},
            '{"e",   1'b0, 1'b0, NO_TOKEN},
            '{"l",   1'b0, 1'b0, NO_TOKEN},
            '{"s",   1'b0, 1'b0, NO_TOKEN},
            '{"e",   1'b0, 1'b0, NO_TOKEN},
            '{"!",   1'b0, 1'b0, NO_TOKEN},
            '{"a",   1'b0, 1'b0, NO_TOKEN},
            '{"7",   1'b0, 1'b0, NO_TOKEN},
            '{">",   1'b0, 1'b0, NO_TOKEN},
            '{"=",   1'b0, 1'b0, NO_TOKEN},
            '{"0",   1'b0, 1'b0, NO_TOKEN},
            '{8'h09, 1'b0, 1'b0, NO_TOKEN},
            '{8'hFF, 1'b0, 1'b1, '{KIND_BAD, 16'd12, 17'd1, 64'd0, 1'b1}},
            '{"z",   1'b0, 1'b0, NO_TOKEN},
            '{"5",   1'b1, 1'b1, '{KIND_END, 16'd15, 17'd0, 64'd0, 1'b1}},
            '{8'h01, 1'b0, 1'b1, '{KIND_BAD, 16'd0, 17'd1, 64'd0, 1'b1}},
            '{8'h80, 1'b1, 1'b1, '{KIND_END, 16'd2, 17'd0, 64'd0, 1'b1}},
            '{"r",   1'b0, 1'b0, NO_TOKEN},
            '{"e",   1'b0, 1'b0, NO_TOKEN},
            '{"t",   1'b0, 1'b0, NO_TOKEN},
            '{"u",   1'b0, 1'b0, NO_TOKEN},
            '{"r",   1'b0, 1'b0, NO_TOKEN},
            '{"n",   1'b1, 1'b0, NO_TOKEN},
            '{"<",   1'b1, 1'b0, NO_TOKEN},
            '{" ",   1'b1, 1'b1, '{KIND_END, 16'd1, 17'd0, 64'd0, 1'b1}}
        };

        rst_n         <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.ch    <= CH_SPACE;
        text_if.last  <= 1'b0;
        reset_scanner();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].ch, directed_rows[i].last, 1'b0,
                      directed_rows[i].typed, directed_rows[i].tok);

        scanned_bytes = 0;
        while (scanned_bytes < RANDOM_BYTES)
            send_text();
        text_if.valid <= 1'b0;

        while (awaited_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("c_subset_tokenizer_core: match");
        else
            $display("c_subset_tokenizer_core: mismatch");
        $finish;
    end

endmodule
